/* src/imuca_pkg.sv */
// Shared types, constants and helper functions of the IMU attitude unit.
`timescale 1ns / 1ps

package imuca_pkg;

	// Field widths of the sample and attitude payloads.
	localparam int unsigned AXIS_W     = 16;
	localparam int unsigned ANGLE_W    = 32;
	localparam int unsigned OFS_W      = 11;
	localparam int unsigned GAIN_W     = 16;
	localparam int unsigned BLEND_W    = 16;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 3;

	// Internal datapath widths.
	localparam int unsigned RATE_W  = AXIS_W + 1;   // corrected gyro count
	localparam int unsigned MUL_A_W = 35;           // blend difference
	localparam int unsigned MUL_B_W = 17;           // unsigned factor with a sign bit
	localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
	localparam int unsigned GYRO_W  = 34;           // gyro-integrated angle
	localparam int unsigned SUM_W   = 37;           // blended angle before saturation

	// CORDIC constants: micro-rotation angles in Q24 degrees.
	localparam int unsigned CORDIC_STEPS_DEF = 16;
	localparam int unsigned ANGLE_FRAC_BITS  = 16;
	localparam int unsigned TABLE_FRAC       = 24;
	localparam int unsigned ATAN_IDX_W       = 5;
	localparam int unsigned ATAN_W           = 30;
	localparam int unsigned XY_W             = 36;
	localparam int unsigned Z_W              = 35;
	localparam int unsigned ROUND_SH         = TABLE_FRAC - ANGLE_FRAC_BITS;
	localparam logic signed [Z_W-1:0] HALF_TURN_Q = 35'sd3019898880;
	localparam logic signed [Z_W-1:0] ROUND_HALF  = Z_W'(1) <<< (ROUND_SH - 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFS_X  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFS_Y  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFS_Z  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND  = 3'd5;

	// Register reset values.
	localparam logic signed [OFS_W-1:0] OFS_X_RST = 11'sd55;
	localparam logic signed [OFS_W-1:0] OFS_Y_RST = 11'sd18;
	localparam logic signed [OFS_W-1:0] OFS_Z_RST = 11'sd10;
	localparam logic [GAIN_W-1:0]       GAIN_RST  = 16'd1024;
	localparam logic [BLEND_W-1:0]      BLEND_RST = 16'd66;

	typedef struct packed {
		logic signed [AXIS_W-1:0] accel_x;
		logic signed [AXIS_W-1:0] accel_y;
		logic signed [AXIS_W-1:0] accel_z;
		logic signed [AXIS_W-1:0] rate_x;
		logic signed [AXIS_W-1:0] rate_y;
		logic signed [AXIS_W-1:0] rate_z;
	} sample_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] roll_deg;
		logic signed [ANGLE_W-1:0] pitch_deg;
		logic signed [ANGLE_W-1:0] yaw_deg;
	} attitude_t;

	// Command and status between the sequencer and the CORDIC unit.
	typedef struct packed {
		logic                     start;
		logic signed [AXIS_W-1:0] y;
		logic signed [AXIS_W-1:0] x;
	} cordic_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cordic_sts_t;

	typedef enum logic [1:0] {
		C_IDLE,
		C_ROT,
		C_ROUND
	} cordic_state_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROLL,
		S_PITCH,
		S_GX,
		S_GY,
		S_GZ,
		S_BR,
		S_BP,
		S_PF,
		S_FIN
	} top_state_t;

	// atan(2^-i) in degrees, Q24.
	function automatic logic [ATAN_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
		logic [ATAN_W-1:0] v;
		case (idx)
			5'd0:    v = 30'd754974720;
			5'd1:    v = 30'd445687602;
			5'd2:    v = 30'd235489088;
			5'd3:    v = 30'd119537938;
			5'd4:    v = 30'd60000934;
			5'd5:    v = 30'd30029717;
			5'd6:    v = 30'd15018523;
			5'd7:    v = 30'd7509719;
			5'd8:    v = 30'd3754917;
			5'd9:    v = 30'd1877466;
			5'd10:   v = 30'd938734;
			5'd11:   v = 30'd469367;
			5'd12:   v = 30'd234684;
			5'd13:   v = 30'd117342;
			5'd14:   v = 30'd58671;
			5'd15:   v = 30'd29335;
			5'd16:   v = 30'd14668;
			5'd17:   v = 30'd7334;
			5'd18:   v = 30'd3667;
			5'd19:   v = 30'd1833;
			5'd20:   v = 30'd917;
			5'd21:   v = 30'd458;
			5'd22:   v = 30'd229;
			5'd23:   v = 30'd115;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Clamp a wide angle to the signed 32-bit range.
	function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		logic signed [ANGLE_W-1:0] r;
		hi = SUM_W'(64'sh7FFF_FFFF);
		lo = -hi - SUM_W'(1);
		if (v > hi) begin
			r = {1'b0, {(ANGLE_W-1){1'b1}}};
		end else if (v < lo) begin
			r = {1'b1, {(ANGLE_W-1){1'b0}}};
		end else begin
			r = v[ANGLE_W-1:0];
		end
		return r;
	endfunction

endpackage

/* src/imuca_stream_if.sv */
// Valid/ready stream channel carrying one payload per transfer.
`timescale 1ns / 1ps

interface imuca_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/imuca_cordic.sv */
// Iterative vectoring CORDIC computing atan2(y, x) in degrees, one rotation per cycle.
`timescale 1ns / 1ps

module imuca_cordic #(
	parameter int unsigned CORDIC_STEPS = imuca_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  imuca_pkg::cordic_cmd_t                 cmd,
	output imuca_pkg::cordic_sts_t                 sts,
	output logic signed [imuca_pkg::ANGLE_W-1:0]   angle
);
	import imuca_pkg::*;

	localparam int unsigned CNT_W = $clog2(CORDIC_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

	cordic_state_t state_q, state_d;

	logic signed [XY_W-1:0]    x_q, y_q;
	logic signed [Z_W-1:0]     z_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      done_q;
	logic signed [ANGLE_W-1:0] angle_q;

	logic signed [RATE_W-1:0] xe, ye, xm, ym;
	logic signed [XY_W-1:0]   dx, dy;
	logic signed [Z_W-1:0]    da, rounded;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: a zero y operand skips the rotations.
	always_comb begin
		state_d = state_q;
		case (state_q)
			C_IDLE: begin
				if (cmd.start) begin
					state_d = (cmd.y == '0) ? C_ROUND : C_ROT;
				end
			end
			C_ROT: begin
				if (cnt_q == CNT_LAST) begin
					state_d = C_ROUND;
				end
			end
			C_ROUND: state_d = C_IDLE;
			default: state_d = C_IDLE;
		endcase
	end

	// Operand conditioning: the left half-plane is folded over by negating the vector.
	assign xe = RATE_W'(cmd.x);
	assign ye = RATE_W'(cmd.y);
	assign xm = cmd.x[AXIS_W-1] ? -xe : xe;
	assign ym = cmd.x[AXIS_W-1] ? -ye : ye;

	// Shared shifter and adders of one micro-rotation.
	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign da = Z_W'({1'b0, atan_q24(ATAN_IDX_W'(cnt_q))});
	assign rounded = (z_q + ROUND_HALF) >>> ROUND_SH;

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (cmd.start) begin
					x_q   <= XY_W'(xm) <<< 16;
					y_q   <= XY_W'(ym) <<< 16;
					cnt_q <= '0;
					if (cmd.y == '0) begin
						z_q <= cmd.x[AXIS_W-1] ? HALF_TURN_Q : '0;
					end else if (cmd.x[AXIS_W-1]) begin
						z_q <= cmd.y[AXIS_W-1] ? -HALF_TURN_Q : HALF_TURN_Q;
					end else begin
						z_q <= '0;
					end
				end
			end
			C_ROT: begin
				if (y_q >= 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + da;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - da;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
			C_ROUND: angle_q <= rounded[ANGLE_W-1:0];
			default: ;
		endcase
	end

	// Completion pulse, registered in the cycle after the rounding state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == C_ROUND);
		end
	end

	assign sts.busy = (state_q != C_IDLE);
	assign sts.done = done_q;
	assign angle    = angle_q;

endmodule

/* src/imuca_mul.sv */
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module imuca_mul (
	input  logic                                  clk,
	input  logic signed [imuca_pkg::MUL_A_W-1:0]  a,
	input  logic signed [imuca_pkg::MUL_B_W-1:0]  b,
	output logic signed [imuca_pkg::PROD_W-1:0]   prod
);
	import imuca_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	// One product per cycle, available the cycle after the operands.
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

/* src/imu_complementary_attitude_unit.sv */
// Top level of the IMU attitude unit: sequencer, configuration and angle state.
//
// One six-axis sample enters on the sample channel and one roll/pitch/yaw
// result leaves on the attitude channel; both are valid/ready streams, a
// transfer taking place when valid and ready are high at a rising edge.
// Configuration is written through wr_en/wr_index/wr_data; the user must
// write it only while the unit is idle, as the unit itself does not
// enforce this. Indexes beyond the register list are ignored.
// When enabled, the single CORDIC unit runs atan2 for roll and then for
// pitch, one micro-rotation per cycle, and the one shared multiplier then
// forms the three gyro steps and the two blends in successive cycles. An
// atan2 run with a zero y operand skips its rotations. When disabled, the
// held angles are passed to the result without an update.
// The result sits in an output register; a new sample is taken while it
// waits, and the unit only stalls when a second result is ready before the
// first has been taken. Reset clears the angles to zero and loads the
// register defaults, with the unit disabled.
`timescale 1ns / 1ps

module imu_complementary_attitude_unit #(
	parameter int unsigned CORDIC_STEPS = imuca_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [imuca_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [imuca_pkg::CFG_DATA_W-1:0]    wr_data,
	imuca_stream_if.sink                        sample,
	imuca_stream_if.source                      attitude
);
	import imuca_pkg::*;

	top_state_t state_q, state_d;

	// Configuration registers.
	logic                     enable_q;
	logic signed [OFS_W-1:0]  ofs_x_q, ofs_y_q, ofs_z_q;
	logic [GAIN_W-1:0]        gain_q;
	logic [BLEND_W-1:0]       blend_q;

	// Angle state and working registers.
	logic signed [ANGLE_W-1:0] roll_q, pitch_q, yaw_q;
	logic signed [AXIS_W-1:0]  ax_q, az_q;
	logic signed [RATE_W-1:0]  gx_q, gy_q, gz_q;
	logic signed [ANGLE_W-1:0] roll_acc_q, pitch_acc_q;
	logic signed [GYRO_W-1:0]  gr_q, gp_q;
	attitude_t                 out_q;
	logic                      out_valid_q;

	logic                      take, out_load;
	cordic_cmd_t               cord_cmd;
	cordic_sts_t               cord_sts;
	logic signed [ANGLE_W-1:0] cord_angle;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [GYRO_W-1:0]  step;
	logic signed [SUM_W-1:0]   blend_step;

	assign take = sample.valid && sample.ready;
	assign sample.ready = (state_q == S_IDLE);

	imuca_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cord_cmd),
		.sts   (cord_sts),
		.angle (cord_angle)
	);

	imuca_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.prod(prod)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			ofs_x_q  <= OFS_X_RST;
			ofs_y_q  <= OFS_Y_RST;
			ofs_z_q  <= OFS_Z_RST;
			gain_q   <= GAIN_RST;
			blend_q  <= BLEND_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_ENABLE: enable_q <= wr_data[0];
				REG_OFS_X:  ofs_x_q  <= wr_data[OFS_W-1:0];
				REG_OFS_Y:  ofs_y_q  <= wr_data[OFS_W-1:0];
				REG_OFS_Z:  ofs_z_q  <= wr_data[OFS_W-1:0];
				REG_GAIN:   gain_q   <= wr_data[GAIN_W-1:0];
				REG_BLEND:  blend_q  <= wr_data[BLEND_W-1:0];
				default: ;
			endcase
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, CORDIC commands and multiplier operands.
	always_comb begin
		state_d       = state_q;
		cord_cmd.start = 1'b0;
		cord_cmd.y     = ax_q;
		cord_cmd.x     = az_q;
		mul_a          = '0;
		mul_b          = '0;
		out_load       = 1'b0;
		case (state_q)
			S_IDLE: begin
				cord_cmd.y = sample.data.accel_y;
				cord_cmd.x = sample.data.accel_z;
				if (take) begin
					cord_cmd.start = enable_q;
					state_d = enable_q ? S_ROLL : S_FIN;
				end
			end
			S_ROLL: begin
				if (cord_sts.done) begin
					cord_cmd.start = 1'b1;
					state_d = S_PITCH;
				end
			end
			S_PITCH: begin
				if (cord_sts.done) begin
					state_d = S_GX;
				end
			end
			S_GX: begin
				mul_a   = MUL_A_W'(gx_q);
				mul_b   = {1'b0, gain_q};
				state_d = S_GY;
			end
			S_GY: begin
				mul_a   = MUL_A_W'(gy_q);
				mul_b   = {1'b0, gain_q};
				state_d = S_GZ;
			end
			S_GZ: begin
				mul_a   = MUL_A_W'(gz_q);
				mul_b   = {1'b0, gain_q};
				state_d = S_BR;
			end
			S_BR: begin
				mul_a   = MUL_A_W'(roll_acc_q) - MUL_A_W'(gr_q);
				mul_b   = {1'b0, blend_q};
				state_d = S_BP;
			end
			S_BP: begin
				mul_a   = MUL_A_W'(pitch_acc_q) - MUL_A_W'(gp_q);
				mul_b   = {1'b0, blend_q};
				state_d = S_PF;
			end
			S_PF: state_d = S_FIN;
			S_FIN: begin
				if (!out_valid_q || attitude.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Scaled products: gyro steps drop 8 bits, blend corrections 16.
	assign step       = GYRO_W'(prod >>> 8);
	assign blend_step = SUM_W'(prod >>> 16);

	// Sample capture and intermediate results.
	always_ff @(posedge clk) begin
		if (take) begin
			ax_q <= sample.data.accel_x;
			az_q <= sample.data.accel_z;
			gx_q <= RATE_W'(sample.data.rate_x) + RATE_W'(ofs_x_q);
			gy_q <= RATE_W'(sample.data.rate_y) + RATE_W'(ofs_y_q);
			gz_q <= RATE_W'(sample.data.rate_z) + RATE_W'(ofs_z_q);
		end
		if (state_q == S_ROLL && cord_sts.done) begin
			roll_acc_q <= cord_angle;
		end
		if (state_q == S_PITCH && cord_sts.done) begin
			pitch_acc_q <= -cord_angle;
		end
		if (state_q == S_GY) begin
			gr_q <= GYRO_W'(roll_q) + step;
		end
		if (state_q == S_GZ) begin
			gp_q <= GYRO_W'(pitch_q) + step;
		end
		if (out_load) begin
			out_q.roll_deg  <= roll_q;
			out_q.pitch_deg <= pitch_q;
			out_q.yaw_deg   <= yaw_q;
		end
	end

	// Angle state, updated with saturation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_q  <= '0;
			pitch_q <= '0;
			yaw_q   <= '0;
		end else begin
			case (state_q)
				S_BR: yaw_q   <= sat_angle(SUM_W'(yaw_q) + SUM_W'(step));
				S_BP: roll_q  <= sat_angle(SUM_W'(gr_q) + blend_step);
				S_PF: pitch_q <= sat_angle(SUM_W'(gp_q) + blend_step);
				default: ;
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (attitude.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign attitude.valid = out_valid_q;
	assign attitude.data  = out_q;

	// The CORDIC unit is free whenever the sequencer waits for a sample.
	a_cordic_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !cord_sts.busy)
		else $error("CORDIC busy while the sequencer is idle");

	// A CORDIC result only arrives while the sequencer waits for it.
	a_cordic_done: assert property (@(posedge clk) disable iff (!arst_n)
		cord_sts.done |-> (state_q == S_ROLL || state_q == S_PITCH))
		else $error("unexpected CORDIC completion");

	// A sample transfer starts either the roll run or, when disabled, the result.
	a_take_next: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == S_ROLL || state_q == S_FIN))
		else $error("sample transfer led to an unexpected state");

	// A new result is only presented from the final state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(attitude.valid) |-> $past(state_q == S_FIN))
		else $error("result presented outside the final state");

endmodule
